FILE: rtl/vwadpcm_pkg.sv
`default_nettype none

package vwadpcm_pkg;

  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned START_W  = 6;
  localparam int unsigned ADJ_W    = 5;
  localparam int unsigned PRED_W   = 12;
  localparam int unsigned STEPIX_W = 7;
  localparam int unsigned STEP_W   = 15;
  localparam int unsigned PCM_W    = 16;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_START_STEP = 3'd0;
  localparam logic [2:0] REG_ADJ_CODE0  = 3'd1;
  localparam logic [2:0] REG_ADJ_CODE1  = 3'd2;
  localparam logic [2:0] REG_ADJ_CODE2  = 3'd3;
  localparam logic [2:0] REG_ADJ_CODE3  = 3'd4;

  localparam logic [ADJ_W-1:0] ADJ_CODE0_RESET = 5'h1F;
  localparam logic [ADJ_W-1:0] ADJ_CODE1_RESET = 5'h02;
  localparam logic [ADJ_W-1:0] ADJ_CODE2_RESET = 5'h1F;
  localparam logic [ADJ_W-1:0] ADJ_CODE3_RESET = 5'h02;

  localparam logic [STEPIX_W-1:0] TWO_BIT_LIMIT = 7'd18;
  localparam logic signed [8:0]   STEPIX_MAX    = 9'sd79;
  localparam logic signed [17:0]  PRED_MIN      = -18'sd2048;
  localparam logic signed [17:0]  PRED_MAX      = 18'sd2047;
  localparam int unsigned         PCM_SHIFT     = 4;  // times 16

  localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [STEP_W-1:0] step_size(input logic [STEPIX_W-1:0] idx);
    logic [STEP_W-1:0] r;
    if (idx > 7'd88) r = STEP_TABLE[88];
    else r = STEP_TABLE[idx];
    return r;
  endfunction

  // Standard IMA index change for the low three bits of a 4-bit code.
  function automatic logic signed [ADJ_W-1:0] four_bit_adjust(input logic [2:0] mag);
    logic signed [ADJ_W-1:0] r;
    case (mag)
      3'd4:    r = 5'sd2;
      3'd5:    r = 5'sd4;
      3'd6:    r = 5'sd6;
      3'd7:    r = 5'sd8;
      default: r = -5'sd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/variable_width_adpcm_decoder_unit.sv
`default_nettype none

// Channel   | Direction | Ports
// ----------+-----------+--------------------------------------------------
// in        | input     | in_valid/in_ready, in_data_byte, in_first_byte,
//           |           | in_final_byte
// out       | output    | out_valid/out_ready, out_pcm_sample,
//           |           | out_last_of_byte, out_end_of_track
// cfg       | APB slave | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr,
//           |           | cfg_pwdata, cfg_prdata, cfg_pready
//
// One code is decoded per cycle, unless the output stalls, from the held byte into the
// output register, so a byte holds two codes when both are 4 bits wide, three when the
// widths mix and four when all four are 2 bits wide. A taken byte goes to the held
// byte before its first code is decoded; the next byte is taken in the cycle its
// predecessor's last code is decoded. A stalled output holds the decode step and the
// held byte. Reset is synchronous, keeps in_ready low and clears state and valid flags.
module variable_width_adpcm_decoder_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [7:0]                           in_data_byte,
  input  wire logic                                 in_first_byte,
  input  wire logic                                 in_final_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [vwadpcm_pkg::PCM_W-1:0]      out_pcm_sample,
  output logic                                      out_last_of_byte,
  output logic                                      out_end_of_track,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [vwadpcm_pkg::ADDR_W-1:0]       cfg_paddr,
  input  wire logic [vwadpcm_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [vwadpcm_pkg::DATA_W-1:0]            cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int unsigned ADJ_W    = vwadpcm_pkg::ADJ_W;
  localparam int unsigned STEPIX_W = vwadpcm_pkg::STEPIX_W;

  // Configuration registers
  logic [vwadpcm_pkg::START_W-1:0] start_step_r;
  logic [ADJ_W-1:0]                adj_r [0:3];

  // Held byte
  logic       busy_r;
  logic [7:0] rem_r;
  logic [1:0] pair_r;
  logic       final_r;

  // Decoder state
  logic signed [vwadpcm_pkg::PRED_W-1:0] pred_r, pred_nxt;
  logic [STEPIX_W-1:0]                   step_r, step_nxt;

  // Output register
  logic                                 out_valid_r;
  logic signed [vwadpcm_pkg::PCM_W-1:0] out_pcm_r;
  logic                                 out_last_r;
  logic                                 out_end_r;

  logic                            cfg_wr;
  logic [2:0]                      cfg_idx;
  logic                            advance, accept;
  logic                            use_two, last_code;
  logic [2:0]                      pair_sum;
  logic [vwadpcm_pkg::STEP_W-1:0]  step_val;
  logic [15:0]                     mag;
  logic                            neg;
  logic signed [ADJ_W-1:0]         adj;
  logic signed [17:0]              pred_sum;
  logic signed [8:0]               idx_sum;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_comb begin
    case (cfg_idx)
      vwadpcm_pkg::REG_START_STEP: cfg_prdata = {26'd0, start_step_r};
      vwadpcm_pkg::REG_ADJ_CODE0:  cfg_prdata = {{27{adj_r[0][4]}}, adj_r[0]};
      vwadpcm_pkg::REG_ADJ_CODE1:  cfg_prdata = {{27{adj_r[1][4]}}, adj_r[1]};
      vwadpcm_pkg::REG_ADJ_CODE2:  cfg_prdata = {{27{adj_r[2][4]}}, adj_r[2]};
      vwadpcm_pkg::REG_ADJ_CODE3:  cfg_prdata = {{27{adj_r[3][4]}}, adj_r[3]};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_step_r <= '0;
      adj_r[0]     <= vwadpcm_pkg::ADJ_CODE0_RESET;
      adj_r[1]     <= vwadpcm_pkg::ADJ_CODE1_RESET;
      adj_r[2]     <= vwadpcm_pkg::ADJ_CODE2_RESET;
      adj_r[3]     <= vwadpcm_pkg::ADJ_CODE3_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vwadpcm_pkg::REG_START_STEP: start_step_r <= cfg_pwdata[5:0];
        vwadpcm_pkg::REG_ADJ_CODE0:  adj_r[0] <= cfg_pwdata[4:0];
        vwadpcm_pkg::REG_ADJ_CODE1:  adj_r[1] <= cfg_pwdata[4:0];
        vwadpcm_pkg::REG_ADJ_CODE2:  adj_r[2] <= cfg_pwdata[4:0];
        vwadpcm_pkg::REG_ADJ_CODE3:  adj_r[3] <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Decode step for the code at the bottom of the held byte.
  always_comb begin
    step_val = vwadpcm_pkg::step_size(step_r);
    // A 4-bit code never starts in the top pair of the byte.
    use_two  = (step_r < vwadpcm_pkg::TWO_BIT_LIMIT) || (pair_r == 2'd3);
    mag      = {4'd0, step_val[14:3]};
    if (use_two) begin
      if (rem_r[0]) mag = mag + {1'b0, step_val};
      neg = rem_r[1];
      adj = adj_r[rem_r[1:0]];
      pair_sum = {1'b0, pair_r} + 3'd1;
    end else begin
      if (rem_r[0]) mag = mag + {3'd0, step_val[14:2]};
      if (rem_r[1]) mag = mag + {2'd0, step_val[14:1]};
      if (rem_r[2]) mag = mag + {1'b0, step_val};
      neg = rem_r[3];
      adj = vwadpcm_pkg::four_bit_adjust(rem_r[2:0]);
      pair_sum = {1'b0, pair_r} + 3'd2;
    end
    last_code = pair_sum[2];

    idx_sum = $signed({2'b00, step_r}) + 9'(adj);
    if (idx_sum < 9'sd0) step_nxt = '0;
    else if (idx_sum > vwadpcm_pkg::STEPIX_MAX) step_nxt = STEPIX_W'(vwadpcm_pkg::STEPIX_MAX);
    else step_nxt = idx_sum[STEPIX_W-1:0];

    pred_sum = neg ? (18'(pred_r) - $signed({2'b00, mag}))
                   : (18'(pred_r) + $signed({2'b00, mag}));
    if (pred_sum < vwadpcm_pkg::PRED_MIN) pred_nxt = vwadpcm_pkg::PRED_MIN[11:0];
    else if (pred_sum > vwadpcm_pkg::PRED_MAX) pred_nxt = vwadpcm_pkg::PRED_MAX[11:0];
    else pred_nxt = pred_sum[11:0];
  end

  assign advance   = busy_r && (!out_valid_r || out_ready);
  assign in_ready  = rst_n && (!busy_r || (advance && last_code));
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_pcm_sample   = out_pcm_r;
  assign out_last_of_byte = out_last_r;
  assign out_end_of_track = out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pred_r      <= '0;
      step_r      <= '0;
    end else begin
      if (accept) busy_r <= 1'b1;
      else if (advance && last_code) busy_r <= 1'b0;

      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      // A first byte restarts the track after the previous byte's last code.
      if (accept && in_first_byte) begin
        pred_r <= '0;
        step_r <= {1'b0, start_step_r};
      end else if (advance) begin
        pred_r <= pred_nxt;
        step_r <= step_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem_r   <= in_data_byte;
      pair_r  <= 2'd0;
      final_r <= in_final_byte;
    end else if (advance) begin
      rem_r  <= use_two ? (rem_r >> 2) : (rem_r >> 4);
      pair_r <= pair_sum[1:0];
    end

    if (advance) begin
      out_pcm_r  <= {pred_nxt, {vwadpcm_pkg::PCM_SHIFT{1'b0}}};
      out_last_r <= last_code;
      out_end_r  <= last_code && final_r;
    end
  end

endmodule

`default_nettype wire
